/* design/sorted_list_engine_core_macros.svh */
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SLEC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted list engine: invariant violated");

// Antecedent that implies a consequent in the same cycle.
`define SLEC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list engine: implication violated");

`endif

/* design/slec_pkg.sv */
// Package with types and constants for the sorted list engine.
`default_nettype none

package slec_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;
  localparam int MAX_RESULTS   = 16;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_READ      = 2'd1,
    OP_DEL_FIRST = 2'd2,
    OP_DEL_ALL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  v;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/sorted_list_engine_core.sv */
// Top level of the sorted list engine: cell chain, sequencer and result register.
`default_nettype none
// Usage:
// The input channel (in_valid, in_stall, operation, value) carries one
// operation per transfer: insert, read out, delete first match or delete
// all matches. The output channel (out_valid, out_stall, entry_value, last,
// status, entry_count) carries the results, the final one of each operation
// marked by last. Insert, delete first and any operation on an empty list
// finish at the input transfer; their single result is valid in the next
// cycle, and one such operation is taken per cycle while out_stall is low.
// Delete all removes one match per cycle after the transfer and loads its
// result once no match is left and the result register is free; the next
// operation is taken only after that result is loaded.
// Read out of n entries rotates the cell chain once per entry and restores
// the original order at its end; the entries are sent from the head in
// list order, and the next operation is taken after the last rotation.
// The result register holds each result until the receiver takes it; while
// a result waits under out_stall, read out pauses before an entry it sends,
// the delete all removals go on, and in_stall stays high. Reset empties the
// list at once (every cell valid bit clears) and drops any pending result.

module sorted_list_engine_core #(
  parameter int DEPTH = slec_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic signed [slec_pkg::DATA_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [slec_pkg::DATA_W-1:0]   entry_value,
  output logic                                 last,
  output logic [1:0]                           status,
  output logic [slec_pkg::COUNT_W-1:0]         entry_count
);
  import slec_pkg::*;
  `include "sorted_list_engine_core_macros.svh"

  localparam int IW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DELALL = 3'b010,
    S_READ   = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [IW-1:0]        occupancy, occupancy_next;
  logic [IW-1:0]        rd_idx, rd_idx_next;
  logic                 removed, removed_next;
  logic signed [DATA_W-1:0] held_v, held_v_next;

  cell_cmd_t            cmd;

  // Chain taps; index DEPTH is the empty slot past the last cell.
  logic signed [DATA_W-1:0] cell_val   [DEPTH+1];
  logic [DEPTH:0]           cell_valid;
  logic [DEPTH-1:0]         cell_take;
  logic [DEPTH-1:0]         cell_match;

  logic                 any_match;
  logic                 in_take;
  logic                 out_free;
  logic                 out_load;
  logic signed [DATA_W-1:0] ld_value;
  logic                 ld_last;
  status_t              ld_status;
  logic [IW-1:0]        ld_count;
  logic                 rd_emit;
  logic                 rd_done;
  logic                 rd_last;
  logic                 list_full;
  logic                 list_empty;
  logic [DEPTH-1:0]     fill_mask;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  assign cell_val[DEPTH]   = '0;
  assign cell_valid[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      slec_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .left_take   (1'b0),
        .left_valid  (1'b1),
        .left_val    (cmd.v),
        .right_valid (cell_valid[i+1]),
        .right_val   (cell_val[i+1]),
        .head_val    (cell_val[0]),
        .val         (cell_val[i]),
        .valid       (cell_valid[i]),
        .take        (cell_take[i]),
        .match       (cell_match[i])
      );
    end else begin : g_body
      slec_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .left_take   (cell_take[i-1]),
        .left_valid  (cell_valid[i-1]),
        .left_val    (cell_val[i-1]),
        .right_valid (cell_valid[i+1]),
        .right_val   (cell_val[i+1]),
        .head_val    (cell_val[0]),
        .val         (cell_val[i]),
        .valid       (cell_valid[i]),
        .take        (cell_take[i]),
        .match       (cell_match[i])
      );
    end
  end

  assign any_match  = |cell_match;
  assign list_full  = (occupancy == IW'(DEPTH));
  assign list_empty = (occupancy == '0);

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;

  // Read out: only the first MAX_RESULTS entries are sent, but the chain
  // always turns a full circle so the list ends in its original order.
  assign rd_emit = (32'(rd_idx) < 32'(MAX_RESULTS));
  assign rd_done = (rd_idx == occupancy - IW'(1));
  assign rd_last = (32'(occupancy) <= 32'(MAX_RESULTS)) ? rd_done
                 : (32'(rd_idx) == 32'(MAX_RESULTS - 1));

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    rd_idx_next    = rd_idx;
    removed_next   = removed;
    held_v_next    = held_v;
    cmd.op         = CELL_HOLD;
    cmd.v          = (state == S_DELALL) ? held_v : value;
    out_load       = 1'b0;
    ld_value       = '0;
    ld_last        = 1'b1;
    ld_status      = ST_OK;
    ld_count       = occupancy;

    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          unique case (op_t'(operation))
            OP_INSERT: begin
              out_load = 1'b1;
              if (list_full) begin
                ld_status = ST_FULL;
              end else begin
                cmd.op         = CELL_INSERT;
                occupancy_next = occupancy + IW'(1);
                ld_count       = occupancy + IW'(1);
              end
            end
            OP_READ: begin
              if (list_empty) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_idx_next = '0;
                state_next  = S_READ;
              end
            end
            OP_DEL_FIRST: begin
              out_load = 1'b1;
              if (list_empty) begin
                ld_status = ST_EMPTY;
              end else if (!any_match) begin
                ld_status = ST_NOMATCH;
              end else begin
                cmd.op         = CELL_REMOVE;
                occupancy_next = occupancy - IW'(1);
                ld_count       = occupancy - IW'(1);
              end
            end
            OP_DEL_ALL: begin
              if (list_empty) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                held_v_next  = value;
                removed_next = 1'b0;
                state_next   = S_DELALL;
              end
            end
          endcase
        end
      end

      S_DELALL: begin
        // One match leaves the chain per cycle until none is left.
        if (any_match) begin
          cmd.op         = CELL_REMOVE;
          occupancy_next = occupancy - IW'(1);
          removed_next   = 1'b1;
        end else if (out_free) begin
          out_load   = 1'b1;
          ld_status  = removed ? ST_OK : ST_NOMATCH;
          state_next = S_IDLE;
        end
      end

      S_READ: begin
        if (!rd_emit || out_free) begin
          cmd.op      = CELL_ROTATE;
          out_load    = rd_emit;
          ld_value    = cell_val[0];
          ld_last     = rd_last;
          rd_idx_next = rd_idx + IW'(1);
          if (rd_done) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rd_idx    <= '0;
      removed   <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      rd_idx    <= rd_idx_next;
      removed   <= removed_next;
    end
  end

  always_ff @(posedge clk) begin
    held_v <= held_v_next;
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      entry_value <= ld_value;
      last        <= ld_last;
      status      <= ld_status;
      entry_count <= COUNT_W'(ld_count);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      fill_mask[i] = (32'(i) < 32'(occupancy));
    end
  end

  `SLEC_ASSERT_ALWAYS(a_occupancy_bound, 32'(occupancy) <= 32'(DEPTH))
  `SLEC_ASSERT_ALWAYS(a_valid_matches_count, cell_valid[DEPTH-1:0] == fill_mask)
  `SLEC_ASSERT_IMPLIES(a_read_nonempty, state == S_READ, occupancy != '0)
  `SLEC_ASSERT_IMPLIES(a_empty_count_zero, out_valid && status == ST_EMPTY, entry_count == '0)

endmodule

`default_nettype wire

/* design/slec_cell.sv */
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none

module slec_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  slec_pkg::cell_cmd_t                cmd,
  input  logic                               left_take,
  input  logic                               left_valid,
  input  logic signed [slec_pkg::DATA_W-1:0] left_val,
  input  logic                               right_valid,
  input  logic signed [slec_pkg::DATA_W-1:0] right_val,
  input  logic signed [slec_pkg::DATA_W-1:0] head_val,
  output logic signed [slec_pkg::DATA_W-1:0] val,
  output logic                               valid,
  output logic                               take,
  output logic                               match
);
  import slec_pkg::*;

  logic ge;

  // The insert slot and everything above it shift up; the chain is sorted,
  // so the first cell at or above the key on a removal is the first match.
  assign take  = !valid || (val > cmd.v);
  assign ge    = valid && (val >= cmd.v);
  assign match = valid && (val == cmd.v);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        CELL_INSERT: begin
          if (take) begin
            valid <= left_take ? left_valid : 1'b1;
          end
        end
        CELL_REMOVE: begin
          if (ge) begin
            valid <= right_valid;
          end
        end
        CELL_HOLD, CELL_ROTATE: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (take) begin
          val <= left_take ? left_val : cmd.v;
        end
      end
      CELL_REMOVE: begin
        if (ge) begin
          val <= right_val;
        end
      end
      CELL_ROTATE: begin
        if (valid) begin
          val <= right_valid ? right_val : head_val;
        end
      end
      CELL_HOLD: begin
        val <= val;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the sorted list engine, with a queue-based list predictor.
`default_nettype none

module testbench;
  import slec_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_OPS   = 250;
  localparam int BLOCK_LEN    = 50;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t              entry_value;
    logic               last;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  // Mirrors the sorted list and holds the results each accepted operation
  // should produce, oldest first.
  class list_tracker;
    word_t        held_values[$];
    list_result_t pending_results[$];
    int           mismatches;
    int           results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // The count field always reflects the list after the operation.
    function void push_result(word_t v, logic lst, status_t st);
      list_result_t r;
      r.entry_value = v;
      r.last        = lst;
      r.status      = st;
      r.entry_count = COUNT_W'(held_values.size());
      pending_results = {pending_results, r};
    endfunction

    function status_t remove_matches(word_t v, bit every);
      int idx;
      bit found;
      if (held_values.size() == 0) return ST_EMPTY;
      idx   = 0;
      found = 1'b0;
      while (idx < held_values.size()) begin
        if (held_values[idx] == v && (every || !found)) begin
          held_values.delete(idx);
          found = 1'b1;
        end else begin
          idx++;
        end
      end
      return found ? ST_OK : ST_NOMATCH;
    endfunction

    function void accept_operation(op_t op, word_t v);
      int      pos;
      int      n;
      status_t st;
      case (op)
        OP_INSERT: begin
          if (held_values.size() >= LIST_DEPTH) begin
            push_result('0, 1'b1, ST_FULL);
          end else begin
            // A new value goes after every entry that is equal to it.
            pos = 0;
            while (pos < held_values.size() && held_values[pos] <= v) pos++;
            held_values.insert(pos, v);
            push_result('0, 1'b1, ST_OK);
          end
        end
        OP_READ: begin
          if (held_values.size() == 0) begin
            push_result('0, 1'b1, ST_EMPTY);
          end else begin
            n = (held_values.size() < MAX_RESULTS) ? held_values.size() : MAX_RESULTS;
            for (int i = 0; i < n; i++) begin
              push_result(held_values[i], (i == n - 1), ST_OK);
            end
          end
        end
        OP_DEL_FIRST: begin
          st = remove_matches(v, 1'b0);
          push_result('0, 1'b1, st);
        end
        default: begin
          st = remove_matches(v, 1'b1);
          push_result('0, 1'b1, st);
        end
      endcase
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("MISMATCH result %0d %s: got %h, wanted %h", results_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report("arrived with nothing pending", got.entry_value, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.entry_value !== want.entry_value)
        report("entry_value", got.entry_value, want.entry_value);
      if (got.last !== want.last)
        report("last", DATA_W'(got.last), DATA_W'(want.last));
      if (got.status !== want.status)
        report("status", DATA_W'(got.status), DATA_W'(want.status));
      if (got.entry_count !== want.entry_count)
        report("entry_count", DATA_W'(got.entry_count), DATA_W'(want.entry_count));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = OP_INSERT;
  word_t              value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  word_t              entry_value;
  logic               last;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;

  int           idle_pct = 0;
  int           stall_pct = 0;
  int           cycle_count = 0;
  list_result_t seen_result;
  list_tracker  tracker = new();

  sorted_list_engine_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_value (entry_value),
    .last        (last),
    .status      (status),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Outputs are read at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result.entry_value = entry_value;
      seen_result.last        = last;
      seen_result.status      = status_t'(status);
      seen_result.entry_count = entry_count;
      tracker.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Holds the operation until a transfer takes place; valid stays high
  // into the next call unless that call starts with an idle cycle.
  task automatic send_op(op_t op, word_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.accept_operation(op, v);
  endtask

  // Mostly values near zero so that duplicates and matches are common.
  function automatic word_t random_value();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return '0;
          3:       return -1;
          default: return 1;
        endcase
      end
      1, 2:    return word_t'($urandom_range(0, 8)) - 4;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Deletes mostly aim at a value the list holds.
  function automatic word_t delete_target();
    int n;
    n = tracker.held_values.size();
    if (n != 0 && $urandom_range(0, 99) < 70) return tracker.held_values[$urandom_range(0, n - 1)];
    return random_value();
  endfunction

  initial begin
    int  roll;
    int  phase;
    bit  grow;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list cases, extremes, duplicates and misses.
    send_op(OP_READ, '0);
    send_op(OP_DEL_FIRST, 5);
    send_op(OP_DEL_ALL, 5);
    send_op(OP_INSERT, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 32'sh8000_0000);
    send_op(OP_INSERT, 0);
    send_op(OP_INSERT, -1);
    send_op(OP_INSERT, 0);
    send_op(OP_INSERT, 1);
    send_op(OP_READ, -1);
    send_op(OP_DEL_FIRST, 42);
    send_op(OP_DEL_FIRST, 0);
    send_op(OP_INSERT, 0);
    send_op(OP_INSERT, 0);
    send_op(OP_READ, 32'sh5A5A_A5A5);
    send_op(OP_DEL_ALL, 0);
    send_op(OP_DEL_ALL, 0);
    send_op(OP_DEL_FIRST, 32'sh8000_0000);
    send_op(OP_READ, '0);

    // Random: alternating blocks that fill the list up to full and drain
    // it back toward empty, across the four idling phases.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      phase = i * 4 / RANDOM_OPS;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 86; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      grow = ((i / BLOCK_LEN) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < (grow ? 72 : 20))
        send_op(OP_INSERT, random_value());
      else if (roll < (grow ? 82 : 30))
        send_op(OP_READ, word_t'($urandom));
      else if (roll < (grow ? 92 : 65))
        send_op(OP_DEL_FIRST, delete_target());
      else
        send_op(OP_DEL_ALL, delete_target());
    end

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/slec_pkg.sv
design/slec_cell.sv
design/sorted_list_engine_core.sv
sim/testbench.sv
